// ===== rtl/core/sm83alu_pkg.sv =====
// ----------------------------------------------------------------------------
// sm83alu_pkg
// Shared types and constants of the SM83 ALU and flag unit: operation codes,
// flag bit positions and the packed layouts of the stream beats.
// ----------------------------------------------------------------------------
`default_nettype none

package sm83alu_pkg;

    localparam int OP_W      = 4;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int BIDX_W    = 3;
    localparam int FLAGS_W   = 4;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    // Flag bit positions in flags_in / flags_out
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 4'd0,
        OP_ADC    = 4'd1,
        OP_AND    = 4'd2,
        OP_CP     = 4'd3,
        OP_CPL    = 4'd4,
        OP_CCF    = 4'd5,
        OP_DEC8   = 4'd6,
        OP_BIT    = 4'd7,
        OP_ADD_HL = 4'd8,
        OP_ADD_SP = 4'd9,
        OP_DEC16  = 4'd10,
        OP_NOP    = 4'd11
    } op_t;

    // Input beat, last field in the lowest bits
    typedef struct packed {
        logic [FLAGS_W-1:0] flags_in;
        logic [BIDX_W-1:0]  bit_index;
        logic [WORD_W-1:0]  word_b;
        logic [WORD_W-1:0]  word_a;
        logic [BYTE_W-1:0]  operand8;
        logic [BYTE_W-1:0]  acc;
        logic [OP_W-1:0]    op;
    } alu_in_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [FLAGS_W-1:0] flags_out;
        logic [WORD_W-1:0]  result16;
        logic [BYTE_W-1:0]  result8;
    } alu_out_t;

    localparam int IN_BITS  = $bits(alu_in_t);
    localparam int OUT_BITS = $bits(alu_out_t);

endpackage

`default_nettype wire

// ===== rtl/core/sm83_alu_flags_unit.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_flags_unit
// 8-bit and 16-bit ALU with Z/N/H/C flags of an SM83 style processor.
// ----------------------------------------------------------------------------
// The unit takes one operation beat per clock while the downstream side keeps
// m_axis_tready high, and returns exactly one result beat for it, in order.
// A beat lands in an input register, passes one short adder and flag network,
// and is caught in a result register. Under backpressure both registers fill
// and s_axis_tready drops; no beat is lost or repeated.
// Op codes 12 to 15 behave as NOP.
`default_nettype none

module sm83_alu_flags_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // op[3:0], acc[11:4], operand8[19:12], word_a[35:20], word_b[51:36],
    // bit_index[54:52], flags_in[58:55], zero fill [63:59]
    input  wire logic [sm83alu_pkg::IN_DATA_W-1:0]   s_axis_tdata,

    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // result8[7:0], result16[23:8], flags_out[27:24], zero fill [31:28]
    output      logic [sm83alu_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    sm83alu_pkg::alu_in_t   in_reg;
    logic                   in_valid_reg;
    sm83alu_pkg::alu_out_t  out_reg;
    logic                   out_valid_reg;

    sm83alu_pkg::alu_out_t  alu_res;
    logic                   out_load;
    logic                   in_load;

    // ------------------------------------------------------------------
    // Handshake: the result register frees when empty or being taken
    // ------------------------------------------------------------------
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (!out_valid_reg || m_axis_tready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_reg <= sm83alu_pkg::alu_in_t'(s_axis_tdata[sm83alu_pkg::IN_BITS-1:0]);
        if (out_load)
            out_reg <= alu_res;
    end

    // ------------------------------------------------------------------
    // ALU and flag network
    // ------------------------------------------------------------------
    logic [8:0]  sum8;
    logic [4:0]  nib8;
    logic        cin;
    logic [7:0]  dec8;
    logic [16:0] sum16;
    logic [12:0] sum12;
    logic [15:0] sp_sum;
    logic [4:0]  sp_nib;
    logic [8:0]  sp_low;
    logic [3:0]  fi;

    always_comb
    begin
        fi  = in_reg.flags_in;
        cin = (sm83alu_pkg::op_t'(in_reg.op) == sm83alu_pkg::OP_ADC) && fi[sm83alu_pkg::FLAG_C];

        sum8   = {1'b0, in_reg.acc} + {1'b0, in_reg.operand8} + {8'd0, cin};
        nib8   = {1'b0, in_reg.acc[3:0]} + {1'b0, in_reg.operand8[3:0]} + {4'd0, cin};
        dec8   = in_reg.operand8 - 8'd1;
        sum16  = {1'b0, in_reg.word_a} + {1'b0, in_reg.word_b};
        sum12  = {1'b0, in_reg.word_a[11:0]} + {1'b0, in_reg.word_b[11:0]};
        sp_sum = in_reg.word_a + {{8{in_reg.operand8[7]}}, in_reg.operand8};
        sp_nib = {1'b0, in_reg.word_a[3:0]} + {1'b0, in_reg.operand8[3:0]};
        sp_low = {1'b0, in_reg.word_a[7:0]} + {1'b0, in_reg.operand8};

        alu_res.result8   = in_reg.acc;
        alu_res.result16  = in_reg.word_a;
        alu_res.flags_out = fi;

        case (sm83alu_pkg::op_t'(in_reg.op))
            sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC:
            begin
                alu_res.result8   = sum8[7:0];
                alu_res.flags_out = {sum8[7:0] == 8'd0, 1'b0, nib8[4], sum8[8]};
            end
            sm83alu_pkg::OP_AND:
            begin
                alu_res.result8   = in_reg.acc & in_reg.operand8;
                alu_res.flags_out = {(in_reg.acc & in_reg.operand8) == 8'd0,
                                     1'b0, 1'b1, 1'b0};
            end
            sm83alu_pkg::OP_CP:
            begin
                alu_res.flags_out = {in_reg.acc == in_reg.operand8, 1'b1,
                                     in_reg.acc[3:0] < in_reg.operand8[3:0],
                                     in_reg.acc < in_reg.operand8};
            end
            sm83alu_pkg::OP_CPL:
            begin
                alu_res.result8                        = ~in_reg.acc;
                alu_res.flags_out[sm83alu_pkg::FLAG_N] = 1'b1;
                alu_res.flags_out[sm83alu_pkg::FLAG_H] = 1'b1;
            end
            sm83alu_pkg::OP_CCF:
            begin
                alu_res.flags_out = {fi[sm83alu_pkg::FLAG_Z], 1'b0, 1'b0,
                                     !fi[sm83alu_pkg::FLAG_C]};
            end
            sm83alu_pkg::OP_DEC8:
            begin
                alu_res.result8   = dec8;
                alu_res.flags_out = {dec8 == 8'd0, 1'b1, dec8[3:0] == 4'hF,
                                     fi[sm83alu_pkg::FLAG_C]};
            end
            sm83alu_pkg::OP_BIT:
            begin
                alu_res.flags_out = {!in_reg.operand8[in_reg.bit_index], 1'b0, 1'b1,
                                     fi[sm83alu_pkg::FLAG_C]};
            end
            sm83alu_pkg::OP_ADD_HL:
            begin
                alu_res.result16  = sum16[15:0];
                alu_res.flags_out = {fi[sm83alu_pkg::FLAG_Z], 1'b0, sum12[12], sum16[16]};
            end
            sm83alu_pkg::OP_ADD_SP:
            begin
                // carries come from the unsigned low-byte add
                alu_res.result16  = sp_sum;
                alu_res.flags_out = {1'b0, 1'b0, sp_nib[4], sp_low[8]};
            end
            sm83alu_pkg::OP_DEC16:
            begin
                alu_res.result16 = in_reg.word_a - 16'd1;
            end
            default:
            begin
                // NOP and unused codes: pass everything through
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(sm83alu_pkg::OUT_DATA_W-sm83alu_pkg::OUT_BITS){1'b0}}, out_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg)
        else $error("input register dropped a stalled beat");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("empty input register refused a beat");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && m_axis_tready |=> m_axis_tvalid)
        else $error("beat did not reach the result register");

    a_and_flags: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && (in_reg.op == sm83alu_pkg::OP_AND) |->
            alu_res.flags_out[sm83alu_pkg::FLAG_H] && !alu_res.flags_out[sm83alu_pkg::FLAG_C])
        else $error("AND produced wrong H/C flags");

endmodule

`default_nettype wire

// ===== tb/sm83_alu_flags_check_pkg.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_flags_check_pkg
// Result predictor and in-order scoreboard for the SM83 ALU and flag unit.
// Each accepted operation beat is turned into the expected result beat, and
// each result beat leaving the unit is compared field by field with the
// oldest expected one.
// ----------------------------------------------------------------------------
package sm83_alu_flags_check_pkg;

    import sm83alu_pkg::*;

    class alu_flags_scoreboard;

        alu_out_t    pending_results[$];
        int unsigned op_count[16];
        int unsigned results_checked;
        int unsigned mismatches;

        // Work out result8, result16 and the new flags for one operation
        function alu_out_t predict_alu_outcome(alu_in_t beat);
            alu_out_t           res;
            logic [FLAGS_W-1:0] fo;
            logic               cin;
            logic [8:0]         sum9;
            logic [4:0]         half5;
            logic [16:0]        sum17;
            logic [12:0]        half13;

            res.result8  = beat.acc;
            res.result16 = beat.word_a;
            fo           = beat.flags_in;

            case (beat.op)
                OP_ADD, OP_ADC:
                begin
                    cin   = (beat.op == OP_ADC) && beat.flags_in[FLAG_C];
                    sum9  = {1'b0, beat.acc} + {1'b0, beat.operand8} + {8'd0, cin};
                    half5 = {1'b0, beat.acc[3:0]} + {1'b0, beat.operand8[3:0]} + {4'd0, cin};
                    res.result8 = sum9[7:0];
                    fo[FLAG_Z]  = (sum9[7:0] == 8'h00);
                    fo[FLAG_N]  = 1'b0;
                    fo[FLAG_H]  = half5[4];
                    fo[FLAG_C]  = sum9[8];
                end
                OP_AND:
                begin
                    res.result8 = beat.acc & beat.operand8;
                    fo[FLAG_Z]  = (res.result8 == 8'h00);
                    fo[FLAG_N]  = 1'b0;
                    fo[FLAG_H]  = 1'b1;
                    fo[FLAG_C]  = 1'b0;
                end
                OP_CP:
                begin
                    fo[FLAG_Z] = (beat.acc == beat.operand8);
                    fo[FLAG_N] = 1'b1;
                    fo[FLAG_H] = (beat.acc[3:0] < beat.operand8[3:0]);
                    fo[FLAG_C] = (beat.acc < beat.operand8);
                end
                OP_CPL:
                begin
                    res.result8 = ~beat.acc;
                    fo[FLAG_N]  = 1'b1;
                    fo[FLAG_H]  = 1'b1;
                end
                OP_CCF:
                begin
                    fo[FLAG_N] = 1'b0;
                    fo[FLAG_H] = 1'b0;
                    fo[FLAG_C] = ~beat.flags_in[FLAG_C];
                end
                OP_DEC8:
                begin
                    res.result8 = beat.operand8 - 8'd1;
                    fo[FLAG_Z]  = (res.result8 == 8'h00);
                    fo[FLAG_N]  = 1'b1;
                    fo[FLAG_H]  = (res.result8[3:0] == 4'hF);
                end
                OP_BIT:
                begin
                    fo[FLAG_Z] = ~beat.operand8[beat.bit_index];
                    fo[FLAG_N] = 1'b0;
                    fo[FLAG_H] = 1'b1;
                end
                OP_ADD_HL:
                begin
                    sum17  = {1'b0, beat.word_a} + {1'b0, beat.word_b};
                    half13 = {1'b0, beat.word_a[11:0]} + {1'b0, beat.word_b[11:0]};
                    res.result16 = sum17[15:0];
                    fo[FLAG_N]   = 1'b0;
                    fo[FLAG_H]   = half13[12];
                    fo[FLAG_C]   = sum17[16];
                end
                OP_ADD_SP:
                begin
                    // offset is signed, but the flags come from the unsigned low byte
                    res.result16 = beat.word_a + {{8{beat.operand8[7]}}, beat.operand8};
                    half5 = {1'b0, beat.word_a[3:0]} + {1'b0, beat.operand8[3:0]};
                    sum9  = {1'b0, beat.word_a[7:0]} + {1'b0, beat.operand8};
                    fo[FLAG_Z] = 1'b0;
                    fo[FLAG_N] = 1'b0;
                    fo[FLAG_H] = half5[4];
                    fo[FLAG_C] = sum9[8];
                end
                OP_DEC16:
                begin
                    res.result16 = beat.word_a - 16'd1;
                end
                default:
                begin
                    // NOP and the spare codes pass everything through
                end
            endcase

            res.flags_out = fo;
            return res;
        endfunction

        function void note_operation(alu_in_t beat);
            op_count[beat.op]++;
            pending_results.push_back(predict_alu_outcome(beat));
        endfunction

        function void check_result(alu_out_t got, realtime t_now);
            alu_out_t want;

            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h with nothing outstanding", t_now, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (got.result8 !== want.result8)
            begin
                $display("%0t: result8 mismatch, expected %h, got %h",
                         t_now, want.result8, got.result8);
                mismatches++;
            end
            if (got.result16 !== want.result16)
            begin
                $display("%0t: result16 mismatch, expected %h, got %h",
                         t_now, want.result16, got.result16);
                mismatches++;
            end
            if (got.flags_out !== want.flags_out)
            begin
                $display("%0t: flags_out mismatch, expected %b, got %b",
                         t_now, want.flags_out, got.flags_out);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

    endclass

endpackage

// ===== tb/sm83_alu_flags_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_flags_unit_tb
// Stream-level regression of the SM83 ALU and flag unit. A directed set of
// corner operations is followed by random beats in four phases: free flow,
// source idling, sink backpressure and both, with a long sink hold-off that
// fills the unit. Every result beat is checked against a predicted one.
// ----------------------------------------------------------------------------
module sm83_alu_flags_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sm83alu_pkg::*;
    import sm83_alu_flags_check_pkg::*;

    localparam int RANDOM_PER_PHASE = 330;
    localparam int HOLD_OFF_CYCLES  = 120;
    localparam int SETTLE_CYCLES    = 10;
    localparam int CYCLE_LIMIT      = 100000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    alu_flags_scoreboard sb;

    int unsigned source_idle_pct = 0;
    int unsigned sink_stall_pct  = 0;
    int unsigned beats_sent      = 0;
    int unsigned cycle_count     = 0;
    logic        hold_request    = 1'b0;
    logic        sink_hold       = 1'b0;

    sm83_alu_flags_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Long sink hold-off, counted here so the source keeps pushing meanwhile
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request <= 1'b0;
                sink_hold    <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                sink_hold    <= 1'b0;
            end
        end
    end

    // Sink: random backpressure, check every accepted result beat
    initial
    begin
        forever
        begin
            m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[OUT_BITS-1:0], $realtime);
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h0F;
            3: return 8'h10;
            4: return 8'h80;
            5: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(11))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0FFF;
            3: return 16'h1000;
            4: return 16'h00FF;
            5: return 16'h8000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic alu_in_t random_operation();
        alu_in_t b;

        // mostly defined ops, now and then a spare code
        if ($urandom_range(9) == 0)
            b.op = 4'($urandom_range(15));
        else
            b.op = 4'($urandom_range(OP_NOP));
        b.acc       = pick_byte();
        b.operand8  = pick_byte();
        b.word_a    = pick_word();
        b.word_b    = pick_word();
        b.bit_index = 3'($urandom_range(7));
        b.flags_in  = 4'($urandom_range(15));
        return b;
    endfunction

    task automatic send_beat(input alu_in_t b);
        while ($urandom_range(99) < source_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-IN_BITS){1'b0}}, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_operation(b);
        beats_sent++;
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [7:0] acc,
                           input logic [7:0] v, input logic [15:0] wa,
                           input logic [15:0] wb, input logic [2:0] bi,
                           input logic [3:0] f);
        alu_in_t b;

        b.op        = op;
        b.acc       = acc;
        b.operand8  = v;
        b.word_a    = wa;
        b.word_b    = wb;
        b.bit_index = bi;
        b.flags_in  = f;
        send_beat(b);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned kinds;

        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Carries, half carries and zero results
        send_op(OP_ADD,    8'hFF, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_op(OP_ADD,    8'h0F, 8'h01, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
        send_op(OP_ADC,    8'h0F, 8'h00, 16'h1234, 16'h0000, 3'd0, 4'h1);
        send_op(OP_ADC,    8'hFF, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h1);
        send_op(OP_ADC,    8'h7F, 8'h80, 16'h0000, 16'h0000, 3'd0, 4'hE);
        send_op(OP_AND,    8'hF0, 8'h0F, 16'h0000, 16'h0000, 3'd0, 4'h1);
        send_op(OP_CP,     8'h42, 8'h42, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_op(OP_CP,     8'h10, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'h8);
        send_op(OP_CP,     8'h00, 8'hFF, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_op(OP_CPL,    8'hA5, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h9);
        send_op(OP_CCF,    8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_op(OP_CCF,    8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
        send_op(OP_DEC8,   8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h1);
        send_op(OP_DEC8,   8'h00, 8'h01, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_op(OP_DEC8,   8'h00, 8'h10, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_op(OP_BIT,    8'h00, 8'h80, 16'h0000, 16'h0000, 3'd7, 4'h8);
        send_op(OP_BIT,    8'h00, 8'hFE, 16'h0000, 16'h0000, 3'd0, 4'h0);
        // Half carry out of bit 11, carry out of bit 15
        send_op(OP_ADD_HL, 8'h00, 8'h00, 16'h0FFF, 16'h0001, 3'd0, 4'h0);
        send_op(OP_ADD_HL, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 3'd0, 4'h8);
        // Signed offset to SP, flags from the low byte
        send_op(OP_ADD_SP, 8'h00, 8'h01, 16'h00FF, 16'h0000, 3'd0, 4'hF);
        send_op(OP_ADD_SP, 8'h00, 8'h80, 16'h0000, 16'h0000, 3'd0, 4'h0);
        send_op(OP_ADD_SP, 8'h00, 8'hFF, 16'hFFF8, 16'h0000, 3'd0, 4'h0);
        send_op(OP_DEC16,  8'h00, 8'h00, 16'h0000, 16'h0000, 3'd0, 4'h5);
        send_op(OP_NOP,    8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
        // Spare codes behave as NOP
        for (int c = OP_NOP + 1; c < 16; c++)
            send_op(4'(c), 8'h5A, 8'hC3, 16'hBEEF, 16'h1357, 3'd3, 4'(c));
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin source_idle_pct = 53; sink_stall_pct = 0;  end
                2: begin source_idle_pct = 0;  sink_stall_pct = 53; end
                default: begin source_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (phase == 0 && i == 100)
                    hold_request <= 1'b1;
                send_beat(random_operation());
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        kinds = 0;
        for (int c = 0; c < 16; c++)
            if (sb.op_count[c] != 0)
                kinds++;
        $display("Sent %0d operation beats covering %0d of 16 op codes, %0d results checked.",
                 beats_sent, kinds, sb.results_checked);
        $display("Ran free flow, source gaps, sink stalls, both, and one long sink hold-off.");
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
